FILE: design/sha1_hash_engine_assert.svh
// Assertion macros shared by the SHA-1 engine RTL.
`ifndef SHA1_HASH_ENGINE_ASSERT_SVH
`define SHA1_HASH_ENGINE_ASSERT_SVH
// Implication checked on every clock edge, off during reset.
`define SHA1_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the cycle after the antecedent.
`define SHA1_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: design/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Types and constants of the SHA-1 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none
package sha1_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       empty_end;
    } t_sha1_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        final_word;
    } t_sha1_out;

    // Round unit control from the sequencer.
    typedef struct packed {
        logic       load;   // copy chain into working regs
        logic       round;  // run one round
        logic       fold;   // add working regs into chain
        logic       init;   // chain back to initial values
        logic       shift;  // shift one byte into the block window
        logic [6:0] rnd;    // round number
    } t_sha1_ctl;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int unsigned ROUNDS = 80;
endpackage
`default_nettype wire

FILE: design/sha1_round.sv
// ----------------------------------------------------------------------------
// sha1_round
// Shared round unit: 16-word block window that also serves as the message
// schedule, working registers and chaining words. Bytes shift into the
// window one per cycle; one round per cycle under control of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module sha1_round (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sha1_pkg::t_sha1_ctl  i_ctl,
    input  wire logic [7:0]           i_byte,    // block byte to shift in
    input  wire logic [2:0]           i_sel,     // chain word to read out
    output logic [31:0]               o_chain
);
    import sha1_pkg::*;

    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_h [5];
    logic [31:0] w, f, k, t, x;

    // Schedule word and round function
    always_comb begin
        x = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w = (i_ctl.rnd < 7'd16) ? r_w[0] : {x[30:0], x[31]};
        if (i_ctl.rnd < 7'd20) begin
            f = (r_b & r_c) | (~r_b & d_sel(r_d));
            k = K0;
        end else if (i_ctl.rnd < 7'd40) begin
            f = r_b ^ r_c ^ r_d;
            k = K1;
        end else if (i_ctl.rnd < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = K2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = K3;
        end
        t = {r_a[26:0], r_a[31:27]} + f + r_e + k + w;
    end

    function automatic logic [31:0] d_sel(logic [31:0] v);
        return v;
    endfunction

    // Shift bytes in big-endian, or shift the 16-word window and append the schedule word each round
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int i = 0; i < 15; i++) r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            r_w[15] <= {r_w[15][23:0], i_byte};
        end else if (i_ctl.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w;
        end
    end

    // Working registers and chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_a, r_b, r_c, r_d, r_e} <= '0;
            r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2; r_h[3] <= H3; r_h[4] <= H4;
        end else begin
            if (i_ctl.load) begin
                r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                r_d <= r_h[3]; r_e <= r_h[4];
            end else if (i_ctl.round) begin
                r_e <= r_d;
                r_d <= r_c;
                r_c <= {r_b[1:0], r_b[31:2]};
                r_b <= r_a;
                r_a <= t;
            end
            if (i_ctl.fold) begin
                r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end else if (i_ctl.init) begin
                r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2;
                r_h[3] <= H3; r_h[4] <= H4;
            end
        end
    end

    assign o_chain = (i_sel < 3'd5) ? r_h[i_sel] : '0;
endmodule
`default_nettype wire

FILE: design/sha1_hash_engine.sv
// ----------------------------------------------------------------------------
// sha1_hash_engine
// SHA-1 over a byte stream; emits the five digest words at message end.
// ----------------------------------------------------------------------------
//  channel | dir | payload     | handshake
//  in      | in  | t_sha1_in   | i_in_valid / o_in_ready
//  out     | out | t_sha1_out  | o_out_valid / i_out_ready
//
// A byte that fills the block starts compression: a load state, the 80
// rounds (one per cycle in the shared round unit) and a fold state.
// Message end adds a padding fill of each padding block (one byte per
// cycle), one or two compressions, then five digest transfers. Input is
// not ready during any of this. Synchronous active-low reset returns to
// idle with the initial chain values.
`default_nettype none
module sha1_hash_engine (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire sha1_pkg::t_sha1_in   i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output sha1_pkg::t_sha1_out       o_out
);
    import sha1_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_RND  = 3'd2;
    localparam logic [2:0] S_FOLD = 3'd3;
    localparam logic [2:0] S_PAD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [60:0] r_cnt;
    logic [5:0]  r_pos;      // padding fill pointer
    logic        r_fin;      // compression belongs to message end
    logic        r_second;   // length block still to be built
    logic        r_mark;     // next padding byte is the end marker
    logic [6:0]  r_rnd;
    logic [2:0]  r_idx;
    logic [63:0] bits;
    logic [31:0] chain;
    logic [7:0]  pad_b;
    logic [7:0]  shift_b;
    t_sha1_ctl   ctl;
    logic        take;
    logic        rnd_last;

    assign take = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign bits = {r_cnt, 3'b000};
    assign rnd_last = (r_rnd == 7'(ROUNDS - 1));

    // Padding byte at fill pointer: marker first, then zeros and length
    always_comb begin
        if (r_mark)
            pad_b = PAD_BYTE;
        else if (!r_second && r_pos >= 6'd56)
            pad_b = bits[{~r_pos[2:0], 3'b000} +: 8];
        else
            pad_b = 8'h00;
    end

    assign shift_b = (r_state == S_PAD) ? pad_b : i_in.data_byte;

    always_comb begin
        ctl.load  = (r_state == S_LOAD);
        ctl.round = (r_state == S_RND);
        ctl.fold  = (r_state == S_FOLD);
        ctl.init  = (r_state == S_OUT) && i_out_ready && (r_idx == 3'd4);
        ctl.shift = (take && !i_in.empty_end) || (r_state == S_PAD);
        ctl.rnd   = r_rnd;
    end

    sha1_round u_round (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ctl),
        .i_byte (shift_b),
        .i_sel  (r_idx),
        .o_chain(chain)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (i_in.empty_end) n_state = S_PAD;
                    else if (r_cnt[5:0] == 6'd63) n_state = S_LOAD;
                    else if (i_in.last) n_state = S_PAD;
                end
            end
            S_LOAD: n_state = S_RND;
            S_RND:  if (rnd_last) n_state = S_FOLD;
            S_FOLD: begin
                if (!r_fin) n_state = S_IDLE;
                else if (r_second) n_state = S_PAD;
                else n_state = S_OUT;
            end
            S_PAD:  if (r_pos == 6'd63) n_state = S_LOAD;
            S_OUT:  if (i_out_ready && r_idx == 3'd4) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_pos    <= '0;
            r_fin    <= 1'b0;
            r_second <= 1'b0;
            r_mark   <= 1'b0;
            r_rnd    <= '0;
            r_idx    <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    r_rnd <= '0;
                    r_idx <= '0;
                    if (take) begin
                        // Decide the end-of-message path
                        r_mark <= 1'b1;
                        if (i_in.empty_end) begin
                            r_fin    <= 1'b1;
                            r_pos    <= r_cnt[5:0];
                            r_second <= (r_cnt[5:0] >= 6'd56);
                        end else begin
                            r_cnt <= r_cnt + 61'd1;
                            r_fin <= i_in.last;
                            if (r_cnt[5:0] == 6'd63) begin
                                // Full block; padding fills a fresh block
                                r_pos    <= 6'd0;
                                r_second <= 1'b1;
                            end else begin
                                r_pos    <= r_cnt[5:0] + 6'd1;
                                r_second <= (r_cnt[5:0] + 6'd1 >= 6'd56);
                            end
                        end
                    end
                end
                S_RND:  r_rnd <= r_rnd + 7'd1;
                S_FOLD: begin
                    r_rnd <= '0;
                    if (r_fin && r_second) begin
                        r_second <= 1'b0;
                        r_pos    <= '0;
                    end
                end
                S_PAD: begin
                    r_pos  <= r_pos + 6'd1;
                    r_mark <= 1'b0;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd4) begin
                            r_cnt <= '0;
                            r_fin <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = (r_state == S_OUT);
    assign o_out.digest_word = chain;
    assign o_out.word_index  = r_idx;
    assign o_out.final_word  = (r_idx == 3'd4);

`include "sha1_hash_engine_assert.svh"
    `SHA1_ASSERT_IMP(a_no_ready_busy, i_clk, i_rst_n, o_out_valid, !o_in_ready, "busy ready")
    `SHA1_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, o_out_valid, r_idx <= 3'd4, "index range")
    `SHA1_ASSERT_NEXT(a_round_adv, i_clk, i_rst_n, ctl.round && !rnd_last, ctl.round, "round skip")
endmodule
`default_nettype wire
